[rtl/cbm_pkg.sv]
package cbm_pkg;

    // Sizing of the cartridge; all three are powers of two.
    localparam int WORK_RAM_BYTES = 8192;
    localparam int PRG_BANK_COUNT = 64;
    localparam int CHR_BANK_COUNT = 256;

    localparam int RAM_AW    = $clog2(WORK_RAM_BYTES);
    localparam int PRG_BANK_W = 6;
    localparam int CHR_BANK_W = 8;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 6;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_PRG_BANK    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_USES_RAM = 1'd1;

    localparam logic [PRG_BANK_W-1:0] LAST_PRG_BANK_RST = 6'd63;
    localparam logic [14:0] IRQ_COUNT_MAX = 15'h7fff;

    // CPU address pages (addr & 0xF800)
    localparam logic [15:0] PAGE_MASK  = 16'hf800;
    localparam logic [15:0] PAGE_SOUND = 16'h4800;
    localparam logic [15:0] PAGE_CNT_LO = 16'h5000;
    localparam logic [15:0] PAGE_CNT_HI = 16'h5800;
    localparam logic [15:0] PAGE_TOP   = 16'hf800;

    typedef enum logic [1:0] {
        OP_CPU_READ  = 2'd0,
        OP_CPU_WRITE = 2'd1,
        OP_CPU_TICK  = 2'd2,
        OP_PPU_FETCH = 2'd3
    } opcode_t;

    typedef struct packed {
        opcode_t     opcode;
        logic [15:0] bus_address;
        logic [7:0]  write_data;
    } in_beat_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        data_driven;
        logic [18:0] prg_rom_address;
        logic [17:0] chr_rom_address;
        logic        nametable_page;
        logic        irq_line;
    } out_beat_t;

    typedef struct packed {
        logic                  en;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_wr_t;

    typedef struct packed {
        logic              rd_en;
        logic              wr_en;
        logic [RAM_AW-1:0] addr;
        logic [7:0]        wdata;
    } ram_req_t;

endpackage

[rtl/cbm_wram.sv]
module cbm_wram (
    input  logic              clk,
    input  logic              rst_n,
    input  cbm_pkg::ram_req_t req,
    output logic [7:0]        rdata,
    output logic              clr_done
);

    logic [7:0] mem [cbm_pkg::WORK_RAM_BYTES];

    logic                      clr_busy_reg;
    logic [cbm_pkg::RAM_AW-1:0] clr_addr_reg;
    logic [7:0]                rdata_reg;

    logic                      wr_en;
    logic [cbm_pkg::RAM_AW-1:0] wr_addr;
    logic [7:0]                wr_data;

    // clearing pass owns the write port until it finishes
    always_comb
    begin
        if (clr_busy_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_addr_reg;
            wr_data = 8'd0;
        end
        else
        begin
            wr_en   = req.wr_en;
            wr_addr = req.addr;
            wr_data = req.wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == cbm_pkg::RAM_AW'(cbm_pkg::WORK_RAM_BYTES - 1))
            begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (req.rd_en)
        begin
            rdata_reg <= mem[req.addr];
        end
    end

    assign rdata    = rdata_reg;
    assign clr_done = !clr_busy_reg;

    // entry 0 is the first step out of reset, so there is no prior step to compare
    a_clr_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (clr_busy_reg && $past(clr_busy_reg) && clr_addr_reg != '0) |->
            (clr_addr_reg == $past(clr_addr_reg) + 1'b1))
        else $error("clear pass skipped an entry");

endmodule

[rtl/cbm_regs.sv]
module cbm_regs (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  cbm_pkg::in_beat_t  beat,
    input  cbm_pkg::cfg_wr_t   cfg,
    output cbm_pkg::out_beat_t result,
    output logic               ram_sel,
    output cbm_pkg::ram_req_t  ram_req
);

    logic [cbm_pkg::PRG_BANK_W-1:0] last_prg_bank_reg;
    logic                           pattern_uses_ram_reg;

    logic [14:0] irq_count_reg, irq_count_next;
    logic        irq_enable_reg, irq_enable_next;
    logic        irq_pending_reg, irq_pending_next;
    logic [cbm_pkg::PRG_BANK_W-1:0] prg_banks_reg [3];
    logic [cbm_pkg::PRG_BANK_W-1:0] prg_banks_next [3];
    logic [cbm_pkg::CHR_BANK_W-1:0] chr_banks_reg [8];
    logic [cbm_pkg::CHR_BANK_W-1:0] chr_banks_next [8];
    logic [3:0]  nt_pages_reg, nt_pages_next;

    logic [15:0] addr;
    logic [7:0]  v;
    logic [15:0] page;
    logic [13:0] ppu_a;
    logic [1:0]  slot;
    logic [cbm_pkg::PRG_BANK_W-1:0] prg_bank;
    logic [cbm_pkg::CHR_BANK_W-1:0] chr_bank;

    always_comb
    begin
        addr  = beat.bus_address;
        v     = beat.write_data;
        page  = addr & cbm_pkg::PAGE_MASK;
        ppu_a = addr[13:0];
        slot  = addr[14:13];

        irq_count_next   = irq_count_reg;
        irq_enable_next  = irq_enable_reg;
        irq_pending_next = irq_pending_reg;
        prg_banks_next   = prg_banks_reg;
        chr_banks_next   = chr_banks_reg;
        nt_pages_next    = nt_pages_reg;

        result  = '0;
        ram_sel = 1'b0;
        ram_req = '0;
        ram_req.addr  = addr[cbm_pkg::RAM_AW-1:0];
        ram_req.wdata = v;

        prg_bank = (slot == 2'd3) ? last_prg_bank_reg
                                  : prg_banks_reg[(slot == 2'd3) ? 2'd0 : slot];
        prg_bank = prg_bank & cbm_pkg::PRG_BANK_W'(cbm_pkg::PRG_BANK_COUNT - 1);
        chr_bank = chr_banks_reg[ppu_a[12:10]]
                 & cbm_pkg::CHR_BANK_W'(cbm_pkg::CHR_BANK_COUNT - 1);

        unique case (beat.opcode)
            cbm_pkg::OP_CPU_READ:
            begin
                if (page == cbm_pkg::PAGE_SOUND)
                begin
                    result.data_driven = 1'b1;
                end
                else if (page == cbm_pkg::PAGE_CNT_LO)
                begin
                    irq_pending_next   = 1'b0;
                    result.read_data   = irq_count_reg[7:0];
                    result.data_driven = 1'b1;
                end
                else if (page == cbm_pkg::PAGE_CNT_HI)
                begin
                    irq_pending_next   = 1'b0;
                    result.read_data   = {irq_enable_reg, irq_count_reg[14:8]};
                    result.data_driven = 1'b1;
                end
                else if (addr[15:13] == 3'b011)
                begin
                    ram_req.rd_en      = 1'b1;
                    ram_sel            = 1'b1;
                    result.data_driven = 1'b1;
                end
                else if (addr[15])
                begin
                    result.prg_rom_address = 19'({prg_bank, addr[12:0]});
                end
            end
            cbm_pkg::OP_CPU_WRITE:
            begin
                if (page == cbm_pkg::PAGE_CNT_LO)
                begin
                    irq_count_next[7:0] = v;
                    irq_pending_next    = 1'b0;
                end
                else if (page == cbm_pkg::PAGE_CNT_HI)
                begin
                    irq_count_next[14:8] = v[6:0];
                    irq_enable_next      = v[7];
                    irq_pending_next     = 1'b0;
                end
                else if (addr[15:13] == 3'b011)
                begin
                    ram_req.wr_en = 1'b1;
                end
                else if (addr[15:14] == 2'b10)
                begin
                    chr_banks_next[addr[13:11]] = v;
                end
                else if (addr[15:13] == 3'b110)
                begin
                    nt_pages_next[addr[12:11]] = v[0];
                end
                else if (addr[15:13] == 3'b111 && page != cbm_pkg::PAGE_TOP)
                begin
                    // E000, E800, F000 -> windows 0..2
                    prg_banks_next[(addr[12:11] == 2'd3) ? 2'd0 : addr[12:11]] =
                        v[cbm_pkg::PRG_BANK_W-1:0];
                end
            end
            cbm_pkg::OP_CPU_TICK:
            begin
                if (irq_enable_reg)
                begin
                    if (irq_count_reg == cbm_pkg::IRQ_COUNT_MAX)
                    begin
                        irq_pending_next = 1'b1;
                    end
                    irq_count_next = irq_count_reg + 15'd1;
                end
            end
            cbm_pkg::OP_PPU_FETCH:
            begin
                if (!ppu_a[13])
                begin
                    if (pattern_uses_ram_reg)
                    begin
                        result.chr_rom_address = 18'(ppu_a[12:0]);
                    end
                    else
                    begin
                        result.chr_rom_address = 18'({chr_bank, ppu_a[9:0]});
                    end
                end
                else if (!ppu_a[12])
                begin
                    result.nametable_page = nt_pages_reg[ppu_a[11:10]];
                end
            end
            default:
            begin
            end
        endcase

        result.irq_line = irq_pending_next;

        if (!accept)
        begin
            ram_req.rd_en = 1'b0;
            ram_req.wr_en = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_prg_bank_reg    <= cbm_pkg::LAST_PRG_BANK_RST;
            pattern_uses_ram_reg <= 1'b0;
            irq_count_reg        <= '0;
            irq_enable_reg       <= 1'b0;
            irq_pending_reg      <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                prg_banks_reg[i] <= cbm_pkg::PRG_BANK_W'(i);
            end
            for (int i = 0; i < 8; i++)
            begin
                chr_banks_reg[i] <= cbm_pkg::CHR_BANK_W'(i);
            end
            nt_pages_reg <= '0;
        end
        else
        begin
            if (cfg.en)
            begin
                unique case (cfg.index)
                    cbm_pkg::CFG_LAST_PRG_BANK:    last_prg_bank_reg <= cfg.data;
                    cbm_pkg::CFG_PATTERN_USES_RAM: pattern_uses_ram_reg <= cfg.data[0];
                    default:
                    begin
                    end
                endcase
            end
            if (accept)
            begin
                irq_count_reg   <= irq_count_next;
                irq_enable_reg  <= irq_enable_next;
                irq_pending_reg <= irq_pending_next;
                prg_banks_reg   <= prg_banks_next;
                chr_banks_reg   <= chr_banks_next;
                nt_pages_reg    <= nt_pages_next;
            end
        end
    end

    a_irq_rise_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(irq_pending_reg) |->
            $past(accept && beat.opcode == cbm_pkg::OP_CPU_TICK && irq_enable_reg))
        else $error("irq pending set without an enabled tick");

endmodule

[rtl/cartridge_bank_mapper_with_irq_counter_top.sv]
// Throughput: one beat per cycle unless stalled; in_ready drops when both result stages
// are full or while the work RAM is being cleared. Work RAM read data is registered, so
// it is ready in the cycle after the access, which sets the extra stage. Reset: all
// bank, counter and config state reset at once; the work RAM is then zeroed by a
// clearing pass over WORK_RAM_BYTES (8192) entries with in_ready low. Config is open.
module cartridge_bank_mapper_with_irq_counter_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  cbm_pkg::in_beat_t                 in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output cbm_pkg::out_beat_t                out_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [cbm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cbm_pkg::CFG_DATA_W-1:0]    cfg_data
);

    logic               accept;
    cbm_pkg::cfg_wr_t   cfg;
    cbm_pkg::out_beat_t step_result;
    logic               step_ram_sel;
    cbm_pkg::ram_req_t  ram_req;
    logic [7:0]         ram_rdata;
    logic               clr_done;

    // stage 1: decoded result, waiting on the work RAM read
    logic               s1_valid_reg;
    cbm_pkg::out_beat_t s1_beat_reg;
    logic               s1_ram_sel_reg;

    // stage 2: output register
    logic               out_valid_reg;
    cbm_pkg::out_beat_t out_beat_reg;

    logic               s2_free;
    logic               s1_move;
    cbm_pkg::out_beat_t s1_merged;

    assign cfg_ready = 1'b1;
    assign cfg.en    = cfg_valid;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    assign s2_free  = !out_valid_reg || out_ready;
    assign s1_move  = s1_valid_reg && s2_free;
    // stage 1 holds while stalled; the RAM read register holds with it since no
    // new beat (and so no new read) is taken
    assign in_ready = clr_done && (!s1_valid_reg || s2_free);
    assign accept   = in_valid && in_ready;

    cbm_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .beat    (in_data),
        .cfg     (cfg),
        .result  (step_result),
        .ram_sel (step_ram_sel),
        .ram_req (ram_req)
    );

    cbm_wram u_wram (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (ram_req),
        .rdata    (ram_rdata),
        .clr_done (clr_done)
    );

    always_comb
    begin
        s1_merged = s1_beat_reg;
        if (s1_ram_sel_reg)
        begin
            s1_merged.read_data = ram_rdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_beat_reg    <= step_result;
            s1_ram_sel_reg <= step_ram_sel;
        end
        if (s1_move)
        begin
            out_beat_reg <= s1_merged;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_beat_reg;

    a_no_accept_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        !clr_done |-> !accept)
        else $error("beat accepted during work RAM clear");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !out_ready) |-> !in_ready)
        else $error("accepted into a full pipeline");

    a_ram_read_tag: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_data.opcode == cbm_pkg::OP_CPU_READ
            && in_data.bus_address[15:13] == 3'b011) |=> (s1_valid_reg && s1_ram_sel_reg))
        else $error("work RAM read not tagged in stage 1");

    a_ram_rd_only_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        ram_req.rd_en |-> accept)
        else $error("RAM read issued without a beat");

endmodule
